FILE: sv/point_segment_range_test_assert.svh
// assertion macros for the point-to-segment range test
// expects clk_i and rst_ni in the module that includes it
`ifndef POINT_SEGMENT_RANGE_TEST_ASSERT_SVH
`define POINT_SEGMENT_RANGE_TEST_ASSERT_SVH

// property must hold at every clock edge outside reset
`define PSRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen outside reset
`define PSRT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: sv/psrt_pkg.sv
// shared widths, types and codes for the point-to-segment range test
// used by every module of the block
package psrt_pkg;

  localparam int COORD_BITS      = 24;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int RANGE_BITS      = 23;
  localparam int KIND_W          = 2;

  localparam int MAG_W  = COORD_BITS + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int REM_W  = SUM_W + 1;
  localparam int PROD_W = MAG_W + RATIO_FRAC_BITS;
  localparam int RR_W   = 2 * RANGE_BITS;

  localparam logic [KIND_W-1:0] KIND_LINE = KIND_W'(1);
  localparam logic [PROD_W-1:0] RATIO_HALF = PROD_W'(1) << (RATIO_FRAC_BITS - 1);

  typedef enum logic [1:0] {
    MODE_ORIGIN,
    MODE_DEST,
    MODE_DIV
  } mode_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   diff_t;
  typedef logic [MAG_W-1:0]             mag_t;
  typedef logic [SQ_W-1:0]              sq_t;
  typedef logic [SUM_W-1:0]             sum_t;
  typedef logic [REM_W-1:0]             rem_t;
  typedef logic [RATIO_FRAC_BITS-1:0]   quo_t;
  typedef logic [RANGE_BITS-1:0]        range_t;
  typedef logic [RR_W-1:0]              rr_t;

  // what the stages from the products up to the first back stage carry along
  typedef struct packed {
    coord_t [2:0] a;
    coord_t [2:0] b;
    coord_t [2:0] p;
    mag_t   [2:0] abm;
    logic   [2:0] abn;
    rr_t          rr;
    mode_e        mode;
  } carry_t;

  typedef struct packed {
    carry_t c;
    rem_t   rem;
    sum_t   lensq;
    quo_t   q;
  } div_t;

  function automatic mag_t abs_diff(diff_t v);
    return v[COORD_BITS] ? mag_t'(-v) : mag_t'(v);
  endfunction

endpackage

FILE: sv/psrt_front.sv
// front stages: differences, products, sums and case decision
// depends on psrt_pkg
module psrt_front import psrt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [KIND_W-1:0]   sound_kind_i,
  input  coord_t [2:0]        origin_i,
  input  coord_t [2:0]        dest_i,
  input  range_t              hear_range_i,
  input  coord_t [2:0]        listener_i,
  output logic                valid_o,
  output div_t                div_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // stage 1
  logic         line1_q;
  coord_t [2:0] a1_q, b1_q, p1_q;
  range_t       rng1_q;
  diff_t  [2:0] ab1_q, ap1_q;

  // stage 2
  logic         line2_q;
  carry_t       c2_q;
  sq_t    [2:0] sq2_q, pr2_q;
  logic   [2:0] ng2_q;

  // stage 3
  logic         line3_q;
  carry_t       c3_q;
  sum_t         len3_q, pos3_q, neg3_q;

  // stage 4
  logic         line4_q, gt4_q, lz4_q;
  carry_t       c4_q;
  sum_t         len4_q, dot4_q;

  div_t         d5_q;

  logic         line2_d;
  carry_t       c2_d;
  sq_t    [2:0] sq2_d, pr2_d;
  logic   [2:0] ng2_d;
  sum_t         len3_d, pos3_d, neg3_d;
  div_t         d5_d;

  always_comb begin
    c2_d      = '0;
    c2_d.a    = a1_q;
    c2_d.b    = b1_q;
    c2_d.p    = p1_q;
    c2_d.rr   = rr_t'(rng1_q) * rr_t'(rng1_q);
    c2_d.mode = MODE_ORIGIN;
    line2_d   = line1_q;
    for (int i = 0; i < 3; i++) begin
      c2_d.abm[i] = abs_diff(ab1_q[i]);
      c2_d.abn[i] = ab1_q[i][COORD_BITS];
      sq2_d[i]    = sq_t'(c2_d.abm[i]) * sq_t'(c2_d.abm[i]);
      pr2_d[i]    = sq_t'(c2_d.abm[i]) * sq_t'(abs_diff(ap1_q[i]));
      ng2_d[i]    = ab1_q[i][COORD_BITS] ^ ap1_q[i][COORD_BITS];
    end
  end

  always_comb begin
    len3_d = '0;
    pos3_d = '0;
    neg3_d = '0;
    for (int i = 0; i < 3; i++) begin
      len3_d = len3_d + sum_t'(sq2_q[i]);
      if (ng2_q[i]) begin
        neg3_d = neg3_d + sum_t'(pr2_q[i]);
      end else begin
        pos3_d = pos3_d + sum_t'(pr2_q[i]);
      end
    end
  end

  always_comb begin
    d5_d       = '0;
    d5_d.c     = c4_q;
    d5_d.lensq = len4_q;
    d5_d.rem   = rem_t'(dot4_q);
    priority if (!line4_q || lz4_q || !gt4_q) begin
      d5_d.c.mode = MODE_ORIGIN;
    end else if (dot4_q >= len4_q) begin
      d5_d.c.mode = MODE_DEST;
    end else begin
      d5_d.c.mode = MODE_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      line1_q <= (sound_kind_i == KIND_LINE);
      a1_q    <= origin_i;
      b1_q    <= dest_i;
      p1_q    <= listener_i;
      rng1_q  <= hear_range_i;
      for (int i = 0; i < 3; i++) begin
        ab1_q[i] <= diff_t'(dest_i[i]) - diff_t'(origin_i[i]);
        ap1_q[i] <= diff_t'(listener_i[i]) - diff_t'(origin_i[i]);
      end
      line2_q <= line2_d;
      c2_q    <= c2_d;
      sq2_q   <= sq2_d;
      pr2_q   <= pr2_d;
      ng2_q   <= ng2_d;
      line3_q <= line2_q;
      c3_q    <= c2_q;
      len3_q  <= len3_d;
      pos3_q  <= pos3_d;
      neg3_q  <= neg3_d;
      line4_q <= line3_q;
      c4_q    <= c3_q;
      len4_q  <= len3_q;
      dot4_q  <= pos3_q - neg3_q;
      gt4_q   <= (pos3_q > neg3_q);
      lz4_q   <= (len3_q == '0);
      d5_q    <= d5_d;
    end
  end

  assign valid_o = v5_q;
  assign div_o   = d5_q;

endmodule

FILE: sv/psrt_div.sv
// restoring divider for the projection ratio, one quotient bit a stage
// depends on psrt_pkg and the assertion macro header
`include "point_segment_range_test_assert.svh"

module psrt_div import psrt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t div_i,
  output logic valid_o,
  output div_t div_o
);

  logic v_q  [RATIO_FRAC_BITS];
  div_t dv_q [RATIO_FRAC_BITS];
  div_t dv_d [RATIO_FRAC_BITS];

  for (genvar k = 0; k < RATIO_FRAC_BITS; k++) begin : g_stage
    div_t src;
    logic vsrc;
    rem_t rem2;
    rem_t lenw;

    if (k == 0) begin : g_first
      assign src  = div_i;
      assign vsrc = valid_i;
    end else begin : g_next
      assign src  = dv_q[k-1];
      assign vsrc = v_q[k-1];
    end

    always_comb begin
      rem2    = {src.rem[REM_W-2:0], 1'b0};
      lenw    = rem_t'(src.lensq);
      dv_d[k] = src;
      if (rem2 >= lenw) begin
        dv_d[k].rem = rem2 - lenw;
        dv_d[k].q   = {src.q[RATIO_FRAC_BITS-2:0], 1'b1};
      end else begin
        dv_d[k].rem = rem2;
        dv_d[k].q   = {src.q[RATIO_FRAC_BITS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= vsrc;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  assign valid_o = v_q[RATIO_FRAC_BITS-1];
  assign div_o   = dv_q[RATIO_FRAC_BITS-1];

  // a division beat always enters with dot below a non-zero length
  `PSRT_NEVER(a_div_len_zero, valid_i && div_i.c.mode == MODE_DIV && div_i.lensq == '0, "division beat with zero length")
  `PSRT_NEVER(a_rem_below_len, valid_o && div_o.c.mode == MODE_DIV && div_o.rem >= rem_t'(div_o.lensq), "remainder not below length")
  `PSRT_ASSERT(a_hold_on_stall, !en_i |=> valid_o == $past(valid_o), "divider moved while held")

endmodule

FILE: sv/psrt_back.sv
// back stages: scaled step, closest point, squared distance and range test
// depends on psrt_pkg
module psrt_back import psrt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  div_t         div_i,
  output logic         valid_o,
  output logic         heard_o,
  output coord_t [2:0] near_o
);

  localparam int NR_W = COORD_BITS + 2;

  logic v1_q, v2_q, v3_q, v4_q;

  carry_t              c1_q;
  logic [2:0][PROD_W-1:0] pr1_q;

  rr_t          rr2_q;
  coord_t [2:0] nr2_q, p2_q;

  rr_t          rr3_q;
  coord_t [2:0] nr3_q;
  sq_t    [2:0] sq3_q;

  logic         heard4_q;
  coord_t [2:0] nr4_q;

  logic [2:0][PROD_W-1:0] pr1_d;
  coord_t [2:0] nr2_d;
  sq_t    [2:0] sq3_d;
  sum_t         dist_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr1_d[i] = PROD_W'(div_i.c.abm[i]) * PROD_W'(div_i.q);
    end
  end

  always_comb begin
    logic [PROD_W-1:0]      rnd;
    mag_t                   step;
    logic signed [NR_W-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      rnd  = pr1_q[i] + RATIO_HALF;
      step = rnd[PROD_W-1:RATIO_FRAC_BITS];
      if (c1_q.abn[i]) begin
        sum = NR_W'(c1_q.a[i]) - $signed({1'b0, step});
      end else begin
        sum = NR_W'(c1_q.a[i]) + $signed({1'b0, step});
      end
      unique case (c1_q.mode)
        MODE_DEST: nr2_d[i] = c1_q.b[i];
        MODE_DIV:  nr2_d[i] = coord_t'(sum);
        default:   nr2_d[i] = c1_q.a[i];
      endcase
    end
  end

  always_comb begin
    diff_t d;
    mag_t  m;
    for (int i = 0; i < 3; i++) begin
      d        = diff_t'(nr2_q[i]) - diff_t'(p2_q[i]);
      m        = abs_diff(d);
      sq3_d[i] = sq_t'(m) * sq_t'(m);
    end
  end

  always_comb begin
    dist_d = '0;
    for (int i = 0; i < 3; i++) begin
      dist_d = dist_d + sum_t'(sq3_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q     <= div_i.c;
      pr1_q    <= pr1_d;
      rr2_q    <= c1_q.rr;
      nr2_q    <= nr2_d;
      p2_q     <= c1_q.p;
      rr3_q    <= rr2_q;
      nr3_q    <= nr2_q;
      sq3_q    <= sq3_d;
      heard4_q <= (dist_d < sum_t'(rr3_q));
      nr4_q    <= nr3_q;
    end
  end

  assign valid_o = v4_q;
  assign heard_o = heard4_q;
  assign near_o  = nr4_q;

endmodule

FILE: sv/point_segment_range_test.sv
// top level of the point-to-segment range test
// depends on psrt_pkg, psrt_front, psrt_div and psrt_back
//
//  channel | valid       | stall       | payload
//  in      | in_valid_i  | in_stall_o  | sound_kind_i .. listener_z_i
//  out     | out_valid_o | out_stall_i | heard_o, near_x_o .. near_z_o
//
// one beat in and one out per cycle while the output is not stalled; 5 front stages,
// one divider stage per ratio bit, 4 back stages
// a stalled output beat holds the whole pipeline, so no beat is lost
// reset clears only the valid bits
module point_segment_range_test import psrt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KIND_W-1:0]   sound_kind_i,
  input  coord_t              origin_x_i,
  input  coord_t              origin_y_i,
  input  coord_t              origin_z_i,
  input  coord_t              dest_x_i,
  input  coord_t              dest_y_i,
  input  coord_t              dest_z_i,
  input  range_t              hear_range_i,
  input  coord_t              listener_x_i,
  input  coord_t              listener_y_i,
  input  coord_t              listener_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                heard_o,
  output coord_t              near_x_o,
  output coord_t              near_y_o,
  output coord_t              near_z_o
);

  logic         en;
  logic         fv, dv;
  div_t         fd, dd;
  coord_t [2:0] org, dst, lst, near;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  assign org = {origin_z_i, origin_y_i, origin_x_i};
  assign dst = {dest_z_i, dest_y_i, dest_x_i};
  assign lst = {listener_z_i, listener_y_i, listener_x_i};

  psrt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .sound_kind_i (sound_kind_i),
    .origin_i     (org),
    .dest_i       (dst),
    .hear_range_i (hear_range_i),
    .listener_i   (lst),
    .valid_o      (fv),
    .div_o        (fd)
  );

  psrt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv),
    .div_i   (fd),
    .valid_o (dv),
    .div_o   (dd)
  );

  psrt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv),
    .div_i   (dd),
    .valid_o (out_valid_o),
    .heard_o (heard_o),
    .near_o  (near)
  );

  assign near_x_o = near[0];
  assign near_y_o = near[1];
  assign near_z_o = near[2];

endmodule

FILE: test/tb_point_segment_range_test.sv
// testbench for the point-to-segment range test: directed table then random beats
// depends on psrt_pkg and point_segment_range_test; predicts each result in place
`timescale 1ns / 1ps

module tb_point_segment_range_test;
  import psrt_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    coord_t [2:0]      org;
    coord_t [2:0]      dst;
    range_t            rng;
    coord_t [2:0]      lis;
  } sound_t;

  typedef struct packed {
    logic         heard;
    coord_t [2:0] near;
  } hit_t;

  localparam logic [KIND_W-1:0] KIND_RIFLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BOOM  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SHOT  = 2'd3;
  localparam coord_t CMAX = 24'sh7fffff;
  localparam coord_t CMIN = -24'sh800000;
  localparam range_t RMAX = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  sound_t snd = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic heard_o;
  coord_t near_x_o, near_y_o, near_z_o;

  hit_t expected_hits[$];
  int errors = 0;
  int send_idle = 0, recv_stall = 0;
  int hold_cycles = 0;
  bit sending_done = 0;

  always #6 clk_i = ~clk_i;

  point_segment_range_test i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .sound_kind_i(snd.kind),
    .origin_x_i(snd.org[0]), .origin_y_i(snd.org[1]), .origin_z_i(snd.org[2]),
    .dest_x_i(snd.dst[0]), .dest_y_i(snd.dst[1]), .dest_z_i(snd.dst[2]),
    .hear_range_i(snd.rng),
    .listener_x_i(snd.lis[0]), .listener_y_i(snd.lis[1]), .listener_z_i(snd.lis[2]),
    .out_valid_o, .out_stall_i, .heard_o, .near_x_o, .near_y_o, .near_z_o
  );

  // closest point and audibility, exact in 64-bit arithmetic
  function automatic hit_t predict_hit(sound_t s);
    hit_t h;
    longint a[3], b[3], p[3], nr[3], ab[3], ap[3];
    longint unsigned lensq, pos, neg, dsq, dot, rem, q, m, stp, rr;
    bit carry;
    lensq = 0; pos = 0; neg = 0; dsq = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = s.org[i]; b[i] = s.dst[i]; p[i] = s.lis[i]; nr[i] = a[i];
    end
    if (s.kind == KIND_LINE) begin
      for (int i = 0; i < 3; i++) begin
        ab[i] = b[i] - a[i];
        ap[i] = p[i] - a[i];
        lensq += ab[i] * ab[i];
        m = (ab[i] < 0 ? -ab[i] : ab[i]) * (ap[i] < 0 ? -ap[i] : ap[i]);
        if ((ab[i] < 0) != (ap[i] < 0)) neg += m;
        else pos += m;
      end
      if (lensq != 0 && pos > neg) begin
        dot = pos - neg;
        if (dot >= lensq) begin
          for (int i = 0; i < 3; i++) nr[i] = b[i];
        end else begin
          rem = dot; q = 0;
          for (int k = 0; k < RATIO_FRAC_BITS; k++) begin
            carry = rem[63];
            rem = rem << 1;
            q = q << 1;
            if (carry || rem >= lensq) begin
              rem -= lensq;
              q |= 1;
            end
          end
          for (int i = 0; i < 3; i++) begin
            m = ab[i] < 0 ? -ab[i] : ab[i];
            stp = (m * q + (64'd1 << (RATIO_FRAC_BITS - 1))) >> RATIO_FRAC_BITS;
            nr[i] = ab[i] < 0 ? a[i] - longint'(stp) : a[i] + longint'(stp);
          end
        end
      end
    end
    for (int i = 0; i < 3; i++) dsq += (nr[i] - p[i]) * (nr[i] - p[i]);
    rr = longint'(s.rng) * longint'(s.rng);
    h.heard = dsq < rr;
    for (int i = 0; i < 3; i++) h.near[i] = coord_t'(nr[i]);
    return h;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return CMAX;
      1: return CMIN;
      2: return coord_t'($urandom_range(0, 4095)) - 24'sd2048;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic sound_t rand_sound();
    sound_t s;
    s.kind = $urandom_range(0, 2) != 0 ? KIND_LINE : KIND_W'($urandom);
    for (int i = 0; i < 3; i++) begin
      s.org[i] = rand_coord();
      s.lis[i] = $urandom_range(0, 1) ? rand_coord() : s.org[i] + coord_t'($urandom_range(0, 511)) - 24'sd256;
      s.dst[i] = $urandom_range(0, 1) ? rand_coord() : s.org[i] + coord_t'($urandom_range(0, 1023)) - 24'sd512;
    end
    if ($urandom_range(0, 19) == 0) s.dst = s.org;
    case ($urandom_range(0, 3))
      0: s.rng = RMAX;
      1: s.rng = range_t'($urandom_range(0, 2048));
      default: s.rng = range_t'($urandom);
    endcase
    return s;
  endfunction

  // send one beat, predicting it as it is accepted; valid stays up afterwards
  task automatic send_sound(sound_t s, bit has_ref, hit_t ref_hit);
    while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    snd <= s;
    do @(posedge clk_i); while (in_stall_o);
    expected_hits = {expected_hits, predict_hit(s)};
    if (has_ref && predict_hit(s) != ref_hit) begin
      $error("table row disagrees with prediction for sound %p", s);
      errors++;
    end
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= recv_stall > 0 && $urandom_range(0, 99) < recv_stall;
    end
  end

  // result check
  always @(posedge clk_i) begin
    hit_t got, exp_hit;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.heard = heard_o;
      got.near = {near_z_o, near_y_o, near_x_o};
      if (expected_hits.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        exp_hit = expected_hits.pop_front();
        if (got.heard != exp_hit.heard) begin
          $error("heard: expected %0d, got %0d", exp_hit.heard, got.heard); errors++;
        end
        if (got.near[0] != exp_hit.near[0]) begin
          $error("near_x: expected %0d, got %0d", exp_hit.near[0], got.near[0]); errors++;
        end
        if (got.near[1] != exp_hit.near[1]) begin
          $error("near_y: expected %0d, got %0d", exp_hit.near[1], got.near[1]); errors++;
        end
        if (got.near[2] != exp_hit.near[2]) begin
          $error("near_z: expected %0d, got %0d", exp_hit.near[2], got.near[2]); errors++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("tb_point_segment_range_test: FAIL");
    $finish;
  end

  typedef struct {
    sound_t s;
    bit     has_ref;
    hit_t   h;
  } row_t;

  function automatic sound_t mk(logic [KIND_W-1:0] k, coord_t ox, coord_t dx, coord_t lx,
                                range_t r);
    sound_t s;
    s.kind = k;
    s.org = {24'sd0, 24'sd0, ox};
    s.dst = {24'sd0, 24'sd0, dx};
    s.lis = {24'sd0, 24'sd0, lx};
    s.rng = r;
    return s;
  endfunction

  function automatic hit_t hx(logic hrd, coord_t x);
    hit_t h;
    h.heard = hrd;
    h.near = {24'sd0, 24'sd0, x};
    return h;
  endfunction

  row_t dir_rows[$];

  task automatic add_row(sound_t s, bit has_ref, hit_t h);
    row_t r;
    r.s = s;
    r.has_ref = has_ref;
    r.h = h;
    dir_rows = {dir_rows, r};
  endtask

  initial begin
    sound_t s;
    // point sounds: origin, range equal to distance is not heard
    add_row(mk(KIND_RIFLE, '0, '0, '0, '0), 1'b1, hx(1'b0, '0));
    add_row(mk(KIND_BOOM, 24'sd256, CMAX, 24'sd512, 23'd256), 1'b1, hx(1'b0, 24'sd256));
    add_row(mk(KIND_SHOT, 24'sd256, CMIN, 24'sd512, 23'd257), 1'b1, hx(1'b1, 24'sd256));
    add_row(mk(KIND_RIFLE, CMAX, '0, CMIN, RMAX), 1'b1, hx(1'b0, CMAX));
    add_row(mk(KIND_SHOT, CMIN, '0, CMIN, RMAX), 1'b1, hx(1'b1, CMIN));
    // zero-length segment
    add_row(mk(KIND_LINE, 24'sd100, 24'sd100, 24'sd300, 23'd201), 1'b1, hx(1'b1, 24'sd100));
    // listener behind origin and beyond dest
    add_row(mk(KIND_LINE, '0, 24'sd1000, -24'sd50, 23'd51), 1'b1, hx(1'b1, '0));
    add_row(mk(KIND_LINE, '0, 24'sd1000, 24'sd1500, 23'd500), 1'b1, hx(1'b0, 24'sd1000));
    add_row(mk(KIND_LINE, CMIN, CMAX, CMAX, RMAX), 1'b1, hx(1'b1, CMAX));
    add_row(mk(KIND_LINE, CMAX, CMIN, CMIN, '0), 1'b1, hx(1'b0, CMIN));
    // interior projections, predicted only
    s = mk(KIND_LINE, '0, 24'sd1000, 24'sd333, 23'd10);
    s.lis[1] = 24'sd5;
    add_row(s, 1'b0, '0);
    s.org = {CMIN, CMAX, CMIN}; s.dst = {CMAX, CMIN, CMAX}; s.lis = '0; s.rng = RMAX;
    add_row(s, 1'b0, '0);
    s.org = {24'sd7, -24'sd3, 24'sd1}; s.dst = {-24'sd9, 24'sd11, 24'sd2};
    s.lis = {24'sd0, 24'sd1, 24'sd0}; s.rng = 23'd20;
    add_row(s, 1'b0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_sound(dir_rows[i].s, dir_rows[i].has_ref, dir_rows[i].h);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? (ph == 1 ? 55 : 23) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 55 : 23) : 0;
      for (int n = 0; n < 420; n++) begin
        if (n == 100 && ph == 0) hold_cycles = 150;
        send_sound(rand_sound(), 1'b0, '0);
      end
      // let the block drain before the next phase
      in_valid_i <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clk_i);
    end
    recv_stall = 0;
    repeat (40) @(posedge clk_i);
    if (errors == 0 && expected_hits.size() == 0)
      $display("tb_point_segment_range_test: PASS");
    else
      $display("tb_point_segment_range_test: FAIL");
    $finish;
  end
endmodule
